// ----- rtl/core/n_queens_first_solution_unit_macros.svh -----
// ----------------------------------------------------------------------------
// N-queens solver assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_FIRST_SOLUTION_UNIT_MACROS_SVH
`define N_QUEENS_FIRST_SOLUTION_UNIT_MACROS_SVH

// same-cycle implication
`define NQFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NQFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/nqfs_pkg.sv -----
// ----------------------------------------------------------------------------
// N-queens solver package
// Widths, constants, register map and controller states.
// ----------------------------------------------------------------------------
package nqfs_pkg;

	localparam int MAX_N  = 16;
	localparam int ROW_W  = $clog2(MAX_N + 1);
	localparam int COL_W  = $clog2(MAX_N);
	localparam int SIZE_W = 5;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [ROW_W-1:0]  N_LIMIT        = ROW_W'(MAX_N);
	localparam logic [SIZE_W-1:0] BOARD_SIZE_RST = SIZE_W'(8);
	localparam logic [ROW_W-1:0]  SIZE_TWO       = ROW_W'(2);
	localparam logic [ROW_W-1:0]  SIZE_THREE     = ROW_W'(3);

	// register index, taken from paddr[2]
	localparam logic REG_BOARD_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_BACK,
		ST_EMIT,
		ST_NONE
	} state_t;

endpackage

// ----- rtl/core/nqfs_if.sv -----
// ----------------------------------------------------------------------------
// N-queens solver channels
// Request and result valid/ready channels.
// ----------------------------------------------------------------------------
interface nqfs_req_if;
	logic valid;
	logic ready;
	logic solve_request;

	modport source (output valid, output solve_request, input ready);
	modport sink (input valid, input solve_request, output ready);
endinterface

interface nqfs_res_if import nqfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] row_index;
	logic [COL_W-1:0] column_index;
	logic             solved;
	logic             last_result;

	modport source (output valid, output row_index, output column_index,
		output solved, output last_result, input ready);
	modport sink (input valid, input row_index, input column_index,
		input solved, input last_result, output ready);
endinterface

// ----- rtl/core/nqfs_cfg.sv -----
// ----------------------------------------------------------------------------
// N-queens solver register block
// APB-style board size register.
// ----------------------------------------------------------------------------
module nqfs_cfg import nqfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [SIZE_W-1:0] board_size
);

	logic [SIZE_W-1:0] board_size_q;
	logic              wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_BOARD_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= BOARD_SIZE_RST;
		end else if (wr_hit) begin
			board_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BOARD_SIZE: prdata = {{(DATA_W-SIZE_W){1'b0}}, board_size_q};
			default:        prdata = '0;
		endcase
	end

	assign board_size = board_size_q;

endmodule

// ----- rtl/core/nqfs_cell.sv -----
// ----------------------------------------------------------------------------
// N-queens solver row cell
// Holds one row's queen and chains the attack check to its neighbor.
// ----------------------------------------------------------------------------
module nqfs_cell import nqfs_pkg::*; (
	input  logic             clk,
	input  logic [COL_W-1:0] cell_idx,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] trial,
	input  logic             wr_en,
	input  logic             conflict_in,
	output logic             conflict_out,
	output logic [COL_W-1:0] col
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] idx_ext;
	logic [ROW_W-1:0] gap;
	logic [ROW_W-1:0] col_ext;
	logic [ROW_W-1:0] trial_ext;
	logic             active;
	logic             hit;

	assign idx_ext   = {1'b0, cell_idx};
	assign col_ext   = {1'b0, col_q};
	assign trial_ext = {1'b0, trial};
	assign active    = idx_ext < row;
	assign gap       = row - idx_ext;

	always_ff @(posedge clk) begin
		if (wr_en && row == idx_ext) begin
			col_q <= trial;
		end
	end

	// same column, or either diagonal
	assign hit = (col_q == trial) || ((col_ext + gap) == trial_ext)
		|| ((trial_ext + gap) == col_ext);

	assign conflict_out = conflict_in | (active & hit);
	assign col          = col_q;

endmodule

// ----- rtl/core/n_queens_first_solution_unit.sv -----
// The search tries one trial position or takes one backtrack step at a time, then emits n words.
// Sizes 0, 2 and 3 give their single word in the cycle after the request.
// Throughput: one request at a time; the next is taken after the last word leaves.
// Reset (arst_n low, async): controller idle, board_size 8; queen cells not cleared.
// ----------------------------------------------------------------------------
// N-queens first-solution unit
// Backtracking search over a chain of row cells, then one word per row, or a single no-solution word.
// ----------------------------------------------------------------------------
`include "n_queens_first_solution_unit_macros.svh"

module n_queens_first_solution_unit import nqfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	nqfs_req_if.sink          req,
	nqfs_res_if.source        res
);

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  trial_q;
	logic [ROW_W-1:0]  n_q;
	logic [COL_W-1:0]  k_q;
	logic [SIZE_W-1:0] board_size;
	logic [ROW_W-1:0]  n_clamp;
	logic [COL_W-1:0]  nm1;
	logic [ROW_W-1:0]  row_inc;
	logic [COL_W-1:0]  prev_row;
	logic [COL_W-1:0]  prev_col;
	logic              safe;
	logic              can_step;
	logic              wr_en;
	logic              req_go;
	logic              res_end;
	logic [MAX_N:0]    chain;
	logic [COL_W-1:0]  cols [MAX_N];

	nqfs_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.board_size (board_size)
	);

	assign chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_N; i++) begin : g_cell
		nqfs_cell u_cell (
			.clk          (clk),
			.cell_idx     (COL_W'(i)),
			.row          (row_q),
			.trial        (trial_q),
			.wr_en        (wr_en),
			.conflict_in  (chain[i]),
			.conflict_out (chain[i+1]),
			.col          (cols[i])
		);
	end

	assign safe     = !chain[MAX_N];
	assign n_clamp  = ({1'b0, board_size} > {1'b0, N_LIMIT}) ? N_LIMIT
		: ROW_W'(board_size);
	assign nm1      = COL_W'(n_q - ROW_W'(1));
	assign row_inc  = row_q + ROW_W'(1);
	assign prev_row = COL_W'(row_q - ROW_W'(1));
	assign prev_col = cols[prev_row];
	assign can_step = {1'b0, trial_q} < {1'b0, nm1};
	assign req_go   = req.valid && req.ready && req.solve_request;
	assign res_end  = res.valid && res.ready && res.last_result;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && req.solve_request) begin
					if (n_clamp == '0 || n_clamp == SIZE_TWO || n_clamp == SIZE_THREE)
						state_d = ST_NONE;
					else
						state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (safe) begin
					if (row_inc >= n_q) state_d = ST_EMIT;
				end else if (!can_step) begin
					state_d = ST_BACK;
				end
			end
			ST_BACK: begin
				if (row_q == '0)           state_d = ST_NONE;
				else if (prev_col != nm1)  state_d = ST_SEARCH;
			end
			ST_EMIT: begin
				if (res.ready && k_q == nm1) state_d = ST_IDLE;
			end
			ST_NONE: begin
				if (res.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready        = 1'b0;
		wr_en            = 1'b0;
		res.valid        = 1'b0;
		res.row_index    = '0;
		res.column_index = '0;
		res.solved       = 1'b0;
		res.last_result  = 1'b0;
		unique case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_SEARCH: wr_en = safe;
			ST_BACK:   ;
			ST_EMIT: begin
				res.valid        = 1'b1;
				res.row_index    = k_q;
				res.column_index = cols[k_q];
				res.solved       = 1'b1;
				res.last_result  = (k_q == nm1);
			end
			ST_NONE: begin
				res.valid       = 1'b1;
				res.last_result = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			trial_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						n_q     <= n_clamp;
						row_q   <= '0;
						trial_q <= '0;
						k_q     <= '0;
					end
				end
				ST_SEARCH: begin
					if (safe) begin
						row_q   <= row_inc;
						trial_q <= '0;
					end else if (can_step) begin
						trial_q <= trial_q + COL_W'(1);
					end
				end
				ST_BACK: begin
					if (row_q != '0) begin
						row_q   <= row_q - ROW_W'(1);
						trial_q <= (prev_col == nm1) ? prev_col : prev_col + COL_W'(1);
					end
				end
				ST_EMIT: begin
					if (res.ready) k_q <= k_q + COL_W'(1);
				end
				default: ;
			endcase
		end
	end

	`NQFS_ASSERT_NOW(a_row_in_range, state_q == ST_SEARCH, row_q < n_q, "row out of range")
	`NQFS_ASSERT_NOW(a_emit_in_range, state_q == ST_EMIT, {1'b0, k_q} < n_q, "emit past size")
	`NQFS_ASSERT_NEXT(a_start_leaves_idle, req_go, state_q != ST_IDLE, "solve request ignored")
	`NQFS_ASSERT_NEXT(a_last_word_to_idle, res_end, state_q == ST_IDLE, "not idle after last word")

endmodule
